FILE: sv/bm25_pkg.sv
// shared types and constants for the bm25 term score accumulator
`default_nettype none

package bm25_pkg;

   localparam int unsigned DfWidth    = 24;
   localparam int unsigned TfWidth    = 16;
   localparam int unsigned LenWidth   = 16;
   localparam int unsigned ScoreWidth = 32;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDatWidth = 32;
   localparam int unsigned ReqDatWidth = 56;

   localparam int unsigned OpWidth  = 26;  // 2N+2 and 2df+1
   localparam int unsigned TopWidth = 5;
   localparam int unsigned LogWidth = 21;  // Q5.16 log2
   localparam int unsigned MantWidth = 31; // Q1.30 mantissa
   localparam int unsigned QuoWidth = 51;
   localparam int unsigned DenWidth = 36;
   localparam int unsigned NormWidth = 41;
   localparam int unsigned KnWidth  = 51;

   localparam logic [31:0] Ln2Q32 = 32'd2977044472;
   localparam logic [5:0]  DivLast = 6'(QuoWidth - 1);
   localparam logic [3:0]  LogLast = 4'd15;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DOC_COUNT  = 3'd0,
      CSR_AVG_LEN    = 3'd1,
      CSR_SAT_GAIN   = 3'd2,
      CSR_LEN_WEIGHT = 3'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_INIT,
      ST_LOG_SQ,
      ST_IDF,
      ST_DIV_RATIO,
      ST_NORM,
      ST_KN_LO,
      ST_KN_HI,
      ST_NUMER,
      ST_DIV_FACTOR,
      ST_TERM,
      ST_ACC,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: sv/bm25_term_score_accumulator.sv
// bm25 term score accumulator: sequencer around one shared multiplier and one divider
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata {doc_length, term_freq, doc_freq}, tlast last_term
// rsp      out  rsp_tvalid/rsp_tready  tdata score, tuser saturated
// csr      in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// a scored term takes two log2 passes of 16 squarings on the shared
// 32x32 multiplier, and two 51-step restoring divisions on the shared divider
// a term with zero df or tf, or df above N, goes straight to the finish step
// reset is synchronous; score, clip flag and registers return to their defaults
// a last term waits in the finish step while an earlier score is still not taken

`default_nettype none

module bm25_term_score_accumulator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // doc_freq [23:0], term_freq [39:24], doc_length [55:40]
   input  wire logic [bm25_pkg::ReqDatWidth-1:0] req_tdata,
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // score [31:0]
   output logic [bm25_pkg::ScoreWidth-1:0]      rsp_tdata,
   // saturated [0]
   output logic                                 rsp_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bm25_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [bm25_pkg::CsrDatWidth-1:0] csr_data
);
   import bm25_pkg::*;

   state_type state_ff, state_in;

   logic [23:0] doc_count_ff, doc_count_in;
   logic [31:0] avg_len_ff, avg_len_in;
   logic [9:0]  k1_ff, k1_in;
   logic [8:0]  b_ff, b_in;

   logic [ScoreWidth-1:0] score_ff, score_in;
   logic                  clip_ff, clip_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ScoreWidth-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic [OpWidth-1:0]   a_ff, a_in, d_ff, d_in;
   logic [TfWidth-1:0]   tf_ff, tf_in;
   logic [LenWidth-1:0]  len_ff, len_in;
   logic                 last_ff, last_in;

   logic                 log_sel_ff, log_sel_in;
   logic [TopWidth-1:0]  top_ff, top_in;
   logic [MantWidth-1:0] mant_ff, mant_in;
   logic [15:0]          frac_ff, frac_in;
   logic [3:0]           log_cnt_ff, log_cnt_in;
   logic [LogWidth-1:0]  loga_ff, loga_in, logd_ff, logd_in;
   logic [LogWidth-1:0]  idf_ff, idf_in;

   logic [DenWidth-1:0]   div_rem_ff, div_rem_in;
   logic [QuoWidth-1:0]   div_quo_ff, div_quo_in;
   logic [DenWidth-1:0]   div_den_ff, div_den_in;
   logic [5:0]            div_cnt_ff, div_cnt_in;

   logic [NormWidth-1:0]  norm_ff, norm_in;
   logic [KnWidth-1:0]    kn_ff, kn_in;
   logic [ScoreWidth-1:0] term_ff, term_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // shared divider step
   logic [DenWidth:0] div_trial, div_diff;
   logic              div_ge;
   assign div_trial = {div_rem_ff, div_quo_ff[QuoWidth-1]};
   assign div_ge    = div_trial >= {1'b0, div_den_ff};
   assign div_diff  = div_trial - {1'b0, div_den_ff};

   logic [OpWidth-1:0]  log_x;
   logic [TopWidth-1:0] log_top;
   logic [33:0]         sq;
   logic [31:0]         ratio;
   logic [8:0]          bq;
   logic [18:0]         kn_hi;
   logic [KnWidth-1:0]  kn_full;
   logic [ScoreWidth:0] sum;

   assign log_x = log_sel_ff ? d_ff : a_ff;
   always_comb begin
      log_top = '0;
      for (int i = 0; i < OpWidth; i++) begin
         if (log_x[i]) begin
            log_top = TopWidth'(i);
         end
      end
   end

   assign sq      = mul_p[63:30];
   assign ratio   = (div_quo_ff[QuoWidth-1:32] != '0) ? 32'hFFFF_FFFF : div_quo_ff[31:0];
   assign bq      = (b_ff > 9'd256) ? 9'd256 : b_ff;
   assign kn_hi   = mul_p[18:0];
   assign kn_full = kn_ff + {kn_hi, 32'd0};
   assign sum     = {1'b0, score_ff} + {1'b0, term_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         doc_count_ff  <= '0;
         avg_len_ff    <= 32'd65536;
         k1_ff         <= 10'd384;
         b_ff          <= 9'd192;
         score_ff      <= '0;
         clip_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         doc_count_ff  <= doc_count_in;
         avg_len_ff    <= avg_len_in;
         k1_ff         <= k1_in;
         b_ff          <= b_in;
         score_ff      <= score_in;
         clip_ff       <= clip_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
      a_ff        <= a_in;
      d_ff        <= d_in;
      tf_ff       <= tf_in;
      len_ff      <= len_in;
      last_ff     <= last_in;
      log_sel_ff  <= log_sel_in;
      top_ff      <= top_in;
      mant_ff     <= mant_in;
      frac_ff     <= frac_in;
      log_cnt_ff  <= log_cnt_in;
      loga_ff     <= loga_in;
      logd_ff     <= logd_in;
      idf_ff      <= idf_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      div_cnt_ff  <= div_cnt_in;
      norm_ff     <= norm_in;
      kn_ff       <= kn_in;
      term_ff     <= term_in;
   end

   // configuration writes
   always_comb begin
      doc_count_in  = doc_count_ff;
      avg_len_in    = avg_len_ff;
      k1_in         = k1_ff;
      b_in          = b_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DOC_COUNT:  doc_count_in  = csr_data[23:0];
            CSR_AVG_LEN:    avg_len_in    = csr_data;
            CSR_SAT_GAIN:   k1_in         = csr_data[9:0];
            CSR_LEN_WEIGHT: b_in          = csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      score_in     = score_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      a_in         = a_ff;
      d_in         = d_ff;
      tf_in        = tf_ff;
      len_in       = len_ff;
      last_in      = last_ff;
      log_sel_in   = log_sel_ff;
      top_in       = top_ff;
      mant_in      = mant_ff;
      frac_in      = frac_ff;
      log_cnt_in   = log_cnt_ff;
      loga_in      = loga_ff;
      logd_in      = logd_ff;
      idf_in       = idf_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      norm_in      = norm_ff;
      kn_in        = kn_ff;
      term_in      = term_ff;
      mul_a        = '0;
      mul_b        = '0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               a_in       = ({2'b00, doc_count_ff} + 26'd1) << 1;
               d_in       = {1'b0, req_tdata[23:0], 1'b1};
               tf_in      = req_tdata[39:24];
               len_in     = req_tdata[55:40];
               last_in    = req_tlast;
               log_sel_in = 1'b0;
               if (req_tdata[23:0] == '0 || req_tdata[39:24] == '0
                   || a_in <= d_in) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_LOG_INIT;
               end
            end
         end
         ST_LOG_INIT: begin
            top_in     = log_top;
            mant_in    = MantWidth'({5'd0, log_x} << (5'd30 - log_top));
            frac_in    = '0;
            log_cnt_in = '0;
            state_in   = ST_LOG_SQ;
         end
         ST_LOG_SQ: begin
            mul_a = {1'b0, mant_ff};
            mul_b = {1'b0, mant_ff};
            // mantissa crossing 2.0 yields a one bit and is halved
            if (sq[31]) begin
               mant_in = sq[31:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               mant_in = sq[30:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
            log_cnt_in = log_cnt_ff + 4'd1;
            if (log_cnt_ff == LogLast) begin
               if (log_sel_ff) begin
                  logd_in  = {top_ff, frac_in};
                  state_in = ST_IDF;
               end else begin
                  loga_in    = {top_ff, frac_in};
                  log_sel_in = 1'b1;
                  state_in   = ST_LOG_INIT;
               end
            end
         end
         ST_IDF: begin
            mul_a      = 32'(loga_ff - logd_ff);
            mul_b      = Ln2Q32;
            idf_in     = mul_p[32+LogWidth-1:32];
            div_rem_in = '0;
            div_quo_in = {3'd0, len_ff, 32'd0};
            div_den_in = {4'd0, (avg_len_ff == '0) ? 32'd1 : avg_len_ff};
            div_cnt_in = '0;
            state_in   = ST_DIV_RATIO;
         end
         ST_DIV_RATIO, ST_DIV_FACTOR: begin
            div_rem_in = div_ge ? div_diff[DenWidth-1:0] : div_trial[DenWidth-1:0];
            div_quo_in = {div_quo_ff[QuoWidth-2:0], div_ge};
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == DivLast) begin
               state_in = (state_ff == ST_DIV_RATIO) ? ST_NORM : ST_TERM;
            end
         end
         ST_NORM: begin
            mul_a    = {23'd0, bq};
            mul_b    = ratio;
            norm_in  = NormWidth'({(9'd256 - bq), 16'd0}) + mul_p[NormWidth-1:0];
            state_in = ST_KN_LO;
         end
         ST_KN_LO: begin
            mul_a    = {22'd0, k1_ff};
            mul_b    = norm_ff[31:0];
            kn_in    = KnWidth'(mul_p[41:0]);
            state_in = ST_KN_HI;
         end
         ST_KN_HI: begin
            mul_a      = {22'd0, k1_ff};
            mul_b      = {23'd0, norm_ff[NormWidth-1:32]};
            div_den_in = {4'd0, tf_ff, 16'd0} + {1'b0, kn_full[KnWidth-1:16]};
            state_in   = ST_NUMER;
         end
         ST_NUMER: begin
            mul_a      = {16'd0, tf_ff};
            mul_b      = {21'd0, 11'({1'b0, k1_ff} + 11'd256)};
            div_rem_in = '0;
            div_quo_in = {mul_p[26:0], 24'd0};
            div_cnt_in = '0;
            state_in   = ST_DIV_FACTOR;
         end
         ST_TERM: begin
            mul_a    = {11'd0, idf_ff};
            mul_b    = div_quo_ff[31:0];
            term_in  = mul_p[47:16];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (sum[ScoreWidth]) begin
               score_in = '1;
               clip_in  = 1'b1;
            end else begin
               score_in = sum[ScoreWidth-1:0];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = score_ff;
               rsp_sat_in   = clip_ff;
               score_in     = '0;
               clip_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire

FILE: sv/bm25_checker.sv
// port-level checks for the bm25 term score accumulator, bound to the top level
`default_nettype none

module bm25_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a stalled score holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled score changed");

   // the sequencer is busy in the cycle after a request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a clipped score is the maximum
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'hFFFF_FFFF)
      else $error("saturated flag without maximum score");

   // no score comes out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("score valid after reset");

endmodule

bind bm25_term_score_accumulator bm25_checker u_bm25_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: test/bm25_term_score_accumulator_tb.sv
// testbench for the bm25 term score accumulator: directed and random terms against a predictor
`default_nettype none

class bm25_score_board;
   logic [23:0] coll_size;
   logic [31:0] avg_len;
   logic [9:0]  k1_gain;
   logic [8:0]  b_weight;
   logic [31:0] running_sum;
   logic        running_clip;
   logic [31:0] want_score[$];
   logic        want_sat[$];
   int          errors;

   function new();
      coll_size = 0;
      avg_len = 32'd65536;
      k1_gain = 10'd384;
      b_weight = 9'd192;
      running_sum = 0;
      running_clip = 0;
      errors = 0;
   endfunction

   function void set_reg(bm25_pkg::csr_index_type idx, logic [31:0] val);
      case (idx)
         bm25_pkg::CSR_DOC_COUNT:  coll_size = val[23:0];
         bm25_pkg::CSR_AVG_LEN:    avg_len = val;
         bm25_pkg::CSR_SAT_GAIN:   k1_gain = val[9:0];
         bm25_pkg::CSR_LEN_WEIGHT: b_weight = val[8:0];
         default: ;
      endcase
   endfunction

   function logic [63:0] log2_fix(logic [63:0] x);
      int top;
      logic [63:0] m, frac;
      top = 0;
      frac = 0;
      for (int i = 0; i < 31; i++)
         if (x[i]) top = i;
      m = (x << (30 - top)) & 64'h7FFF_FFFF;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (64'(top) << 16) | frac;
   endfunction

   function logic [63:0] term_weight(logic [63:0] df, logic [63:0] tf, logic [63:0] len);
      logic [63:0] num_a, den_d, idf, avg, ratio, bq, norm, denom, factor;
      logic [127:0] wide;
      num_a = 2 * 64'(coll_size) + 2;
      den_d = 2 * df + 1;
      if (num_a <= den_d) return 0;
      wide = 128'(log2_fix(num_a) - log2_fix(den_d)) * 128'd2977044472;
      idf = 64'(wide >> 32);
      avg = (avg_len != 0) ? 64'(avg_len) : 64'd1;
      ratio = (len << 32) / avg;
      if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
      bq = (b_weight > 256) ? 64'd256 : 64'(b_weight);
      norm = (256 - bq) * 65536 + bq * ratio;
      denom = (tf << 16) + ((64'(k1_gain) * norm) >> 16);
      factor = ((tf * (64'(k1_gain) + 256)) << 24) / denom;
      wide = 128'(idf) * 128'(factor);
      return 64'(wide >> 16);
   endfunction

   function void note_request(logic [23:0] df, logic [15:0] tf, logic [15:0] len,
                              logic last);
      logic [63:0] sum;
      if (df != 0 && tf != 0) begin
         sum = 64'(running_sum) + term_weight(64'(df), 64'(tf), 64'(len));
         if (sum > 64'hFFFF_FFFF) begin
            sum = 64'hFFFF_FFFF;
            running_clip = 1;
         end
         running_sum = sum[31:0];
      end
      if (last) begin
         want_score.insert(want_score.size(), running_sum);
         want_sat.insert(want_sat.size(), running_clip);
         running_sum = 0;
         running_clip = 0;
      end
   endfunction

   function void check_result(logic [31:0] score, logic sat);
      logic [31:0] es;
      logic        ec;
      if (want_score.size() == 0) begin
         $error("unexpected result score %0h", score);
         errors++;
         return;
      end
      es = want_score.pop_front();
      ec = want_sat.pop_front();
      if (score !== es) begin
         $error("score expected %0h actual %0h", es, score);
         errors++;
      end
      if (sat !== ec) begin
         $error("saturated expected %0b actual %0b", ec, sat);
         errors++;
      end
   endfunction
endclass

module bm25_term_score_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bm25_pkg::*;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tlast;
   logic [ReqDatWidth-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tuser;
   logic [ScoreWidth-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrDatWidth-1:0] csr_data;
   logic stim_done;

   bm25_score_board board;

   bm25_term_score_accumulator i_dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // the block is never ready in the cycle after a request, so the idle edge costs nothing
   task automatic send_term(logic [23:0] df, logic [15:0] tf, logic [15:0] len,
                            logic last, bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      repeat (gap) @(posedge clock);
      req_tvalid <= 1;
      req_tdata <= {len, tf, df};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(df, tf, len, last);
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   // wait until every score has come out, then let a zero-work term drain
   task automatic drain();
      while (board.want_score.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic random_docs(int n_terms, bit gaps);
      logic [23:0] df;
      logic [15:0] tf, len;
      for (int i = 0; i < n_terms; i++) begin
         case ($urandom_range(0, 9))
            0: df = 0;
            1: df = 24'($urandom);
            2: df = 24'($urandom_range(1, 16));
            default: df = (board.coll_size == 0) ? 24'($urandom_range(0, 3))
                          : 24'($urandom_range(0, board.coll_size));
         endcase
         case ($urandom_range(0, 9))
            0: tf = 0;
            1: tf = 16'($urandom);
            default: tf = 16'($urandom_range(1, 20));
         endcase
         len = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
         send_term(df, tf, len, $urandom_range(0, 3) == 0, gaps);
      end
      send_term(24'd1, 16'd1, 16'd1, 1'b1, gaps);
   endtask

   // receiver with random stalls of varying length
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      board = new();
      stim_done = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tlast = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults with N = 0: every term adds nothing
      send_term(24'd5, 16'd3, 16'd10, 1'b1, 0);
      drain();
      write_reg(CSR_DOC_COUNT, 32'd1000);
      send_term(24'd0, 16'd5, 16'd100, 1'b0, 0);
      send_term(24'd10, 16'd0, 16'd100, 1'b0, 0);
      send_term(24'd2000, 16'd4, 16'd100, 1'b0, 0);
      send_term(24'd1, 16'd1, 16'd0, 1'b1, 0);
      send_term(24'd1000, 16'hFFFF, 16'hFFFF, 1'b1, 0);
      send_term(24'hFFFFFF, 16'd1, 16'd1, 1'b1, 0);
      drain();
      write_reg(CSR_DOC_COUNT, 32'hFFFFFF);
      write_reg(CSR_AVG_LEN, 32'd0);
      write_reg(CSR_SAT_GAIN, 32'd1023);
      write_reg(CSR_LEN_WEIGHT, 32'd511);
      write_reg(csr_index_type'(3'd6), 32'hDEAD_BEEF);
      send_term(24'd1, 16'hFFFF, 16'hFFFF, 1'b0, 0);
      send_term(24'd1, 16'hFFFF, 16'd0, 1'b1, 0);
      drain();
      // many high-idf terms with no length penalty
      write_reg(CSR_SAT_GAIN, 32'd0);
      write_reg(CSR_AVG_LEN, 32'hFFFF_FFFF);
      write_reg(CSR_LEN_WEIGHT, 32'd0);
      for (int i = 0; i < 10; i++)
         send_term(24'd1, 16'd1, 16'd1, 1'b0, 0);
      send_term(24'd1, 16'd1, 16'd1, 1'b1, 0);
      send_term(24'hFFFFFE, 16'd2, 16'h8000, 1'b1, 0);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_DOC_COUNT, ph == 0 ? 32'd1 : 32'($urandom_range(0, 24'hFFFFFF)));
         write_reg(CSR_AVG_LEN, ph == 1 ? 32'd1 : 32'($urandom_range(1, 32'h0400_0000)));
         write_reg(CSR_SAT_GAIN, ph == 2 ? 32'd1023 : 32'($urandom_range(0, 1023)));
         write_reg(CSR_LEN_WEIGHT, ph == 3 ? 32'd256 : 32'($urandom_range(0, 256)));
         random_docs(100, ph != 4);
         drain();
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      if (board.errors == 0 && board.want_score.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule

`default_nettype wire
